[rtl/ffba_pkg.sv]
// Shared types, codes and defaults of the first-fit block allocator.
package ffba_pkg;

	localparam int DEF_MAX_BLOCKS   = 64;
	localparam int DEF_HEADER_BYTES = 24;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] request_size;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [1:0]  status;
		logic        moved;
		logic [31:0] copy_length;
	} rsp_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
		logic        is_free;
	} entry_t;

	function automatic int idx_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

[rtl/ffba_stream_if.sv]
// Valid/ready channel carrying one payload per transfer.
interface ffba_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/ffba_table.sv]
// Block table memory: one write port, one read port with registered data.
module ffba_table #(
	parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS
) (
	input  logic                                          clk,
	input  logic                                          rd_en,
	input  logic [ffba_pkg::idx_bits(MAX_BLOCKS)-1:0]     rd_idx,
	output ffba_pkg::entry_t                              rd_data,
	input  logic                                          wr_en,
	input  logic [ffba_pkg::idx_bits(MAX_BLOCKS)-1:0]     wr_idx,
	input  ffba_pkg::entry_t                              wr_data
);
	import ffba_pkg::*;

	entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end
endmodule

[rtl/ffba_ctrl.sv]
// Request sequencer: table scan, allocation bookkeeping and result register.
module ffba_ctrl #(
	parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	ffba_stream_if.sink                                   req,
	ffba_stream_if.source                                 rsp,
	ffba_stream_if.sink                                   cfg,
	output logic                                          rd_en,
	output logic [ffba_pkg::idx_bits(MAX_BLOCKS)-1:0]     rd_idx,
	input  ffba_pkg::entry_t                              rd_data,
	output logic                                          wr_en,
	output logic [ffba_pkg::idx_bits(MAX_BLOCKS)-1:0]     wr_idx,
	output ffba_pkg::entry_t                              wr_data
);
	import ffba_pkg::*;

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = idx_bits(MAX_BLOCKS);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
	localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
	localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_OLD,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] idx_s1;
	logic          rd_vld_s1;
	logic          look_q;
	logic          realloc_q;
	logic [CW-1:0] count_q;
	logic [31:0]   bp_q;
	logic [31:0]   limit_q;
	logic          out_valid_q;

	logic [1:0]    op_q;
	logic [31:0]   size_q;
	logic [31:0]   addr_q;
	logic [33:0]   end_q;
	logic [IW-1:0] old_idx_q;
	logic [31:0]   old_base_q;
	logic [31:0]   old_size_q;
	rsp_t          rsp_q;
	rsp_t          out_q;

	logic hit;
	logic miss;
	logic last;
	logic fits_heap;
	logic alloc_like;
	logic accept;
	logic load_out;

	assign accept     = (state_q == S_IDLE) && req.valid;
	assign alloc_like = (req.payload.opcode == OP_ALLOC) ||
	                    ((req.payload.opcode == OP_REALLOC) && (req.payload.address == 32'd0));
	assign last       = (idx_s1 == count_q - CW'(1));
	assign hit        = rd_vld_s1 && (look_q
	                    ? (({1'b0, rd_data.base} + HDR33) == {1'b0, addr_q})
	                    : (rd_data.is_free && (rd_data.size >= size_q)));
	assign miss       = (state_q == S_SCAN) &&
	                    ((count_q == '0) || (rd_vld_s1 && !hit && last));
	assign fits_heap  = (count_q < MAX_CNT) && (end_q <= {2'b00, limit_q});
	assign load_out   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	assign rd_en  = (state_q == S_SCAN) && (ptr_q < count_q);
	assign rd_idx = ptr_q[IW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = idx_s1[IW-1:0];
		wr_data = rd_data;
		if (state_q == S_FREE_OLD) begin
			wr_en   = 1'b1;
			wr_idx  = old_idx_q;
			wr_data = '{base: old_base_q, size: old_size_q, is_free: 1'b1};
		end else if (state_q == S_SCAN) begin
			if (hit && !look_q) begin
				wr_en           = 1'b1;
				wr_data.is_free = 1'b0;
			end else if (hit && (op_q == OP_FREE) && !rd_data.is_free) begin
				wr_en           = 1'b1;
				wr_data.is_free = 1'b1;
			end else if (miss && !look_q && fits_heap) begin
				wr_en   = 1'b1;
				wr_idx  = count_q[IW-1:0];
				wr_data = '{base: bp_q, size: size_q, is_free: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			idx_s1      <= '0;
			rd_vld_s1   <= 1'b0;
			look_q      <= 1'b0;
			realloc_q   <= 1'b0;
			count_q     <= '0;
			bp_q        <= '0;
			limit_q     <= HEAP_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.payload;
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						ptr_q     <= '0;
						rd_vld_s1 <= 1'b0;
						look_q    <= !alloc_like;
						realloc_q <= (req.payload.opcode == OP_REALLOC) &&
						             (req.payload.address != 32'd0);
						if ((req.payload.opcode == OP_NOP) ||
						    ((req.payload.opcode == OP_FREE) && (req.payload.address == 32'd0)) ||
						    (alloc_like && (req.payload.request_size == 32'd0))) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= rd_en;
					idx_s1    <= ptr_q;
					if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (hit || miss) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= S_DONE;
					end
					if (hit && !look_q && realloc_q) begin
						state_q <= S_FREE_OLD;
					end
					if (miss && !look_q && fits_heap) begin
						count_q <= count_q + CW'(1);
						bp_q    <= end_q[31:0];
						if (realloc_q) begin
							state_q <= S_FREE_OLD;
						end
					end
					if (hit && look_q && (op_q == OP_REALLOC) && !rd_data.is_free &&
					    (rd_data.size < size_q)) begin
						look_q  <= 1'b0;
						ptr_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_FREE_OLD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.payload.opcode;
			size_q <= req.payload.request_size;
			addr_q <= req.payload.address;
			end_q  <= {2'b00, bp_q} + HDR34 + {2'b00, req.payload.request_size};
			rsp_q  <= '0;
			if (alloc_like && (req.payload.request_size == 32'd0) &&
			    (req.payload.opcode != OP_NOP)) begin
				rsp_q.status <= ST_NOSPACE;
			end
		end
		if (state_q == S_SCAN) begin
			if (hit && !look_q) begin
				rsp_q.result_address <= rd_data.base + HDR32;
				rsp_q.status         <= ST_OK;
			end else if (miss && !look_q) begin
				if (fits_heap) begin
					rsp_q.result_address <= bp_q + HDR32;
					rsp_q.status         <= ST_OK;
				end else begin
					rsp_q.result_address <= '0;
					rsp_q.status         <= ST_NOSPACE;
				end
			end else if (miss) begin
				rsp_q.status <= ST_BADFREE;
			end else if (hit) begin
				if (rd_data.is_free) begin
					rsp_q.status <= ST_BADFREE;
				end else if ((op_q == OP_REALLOC) && (rd_data.size >= size_q)) begin
					rsp_q.result_address <= addr_q;
				end
				old_idx_q  <= idx_s1[IW-1:0];
				old_base_q <= rd_data.base;
				old_size_q <= rd_data.size;
			end
		end
		if (state_q == S_FREE_OLD) begin
			rsp_q.moved       <= 1'b1;
			rsp_q.copy_length <= old_size_q;
		end
		if (load_out) begin
			out_q <= rsp_q;
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("block count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("block count moved by other than one");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_SCAN) || (state_q == S_FREE_OLD)))
		else $error("table write outside a request");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("finished result not presented");

endmodule

[rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator.
//
// Channels: req carries opcode, request_size and address; rsp returns
// result_address, status, moved and copy_length, one result per request;
// cfg writes heap_limit and is always ready. All three transfer on valid
// and ready high at a rising edge of clk.
// A request walks the block table in creation order, one entry per cycle
// through the table memory's read port. Allocate, free and a reallocate
// that keeps its block take a single scan; a reallocate that moves runs the
// lookup and the fit scan back to back. Trivial requests (null free, zero
// size, no operation) skip the scan. req is ready again in the same cycle
// as a result is presented.
// One request is in flight at a time; req is ready again once its result is
// in the output register, so the next request starts while rsp stalls. A
// second result waits in the sequencer until the output register frees.
// arst_n empties the table (block count and break pointer to zero) and sets
// heap_limit to 65536; the memory itself needs no clearing.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
	input logic           clk,
	input logic           arst_n,
	ffba_stream_if.sink   req,
	ffba_stream_if.source rsp,
	ffba_stream_if.sink   cfg
);
	import ffba_pkg::*;

	localparam int IW = idx_bits(MAX_BLOCKS);

	logic          rd_en;
	logic [IW-1:0] rd_idx;
	entry_t        rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	entry_t        wr_data;

	ffba_ctrl #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	ffba_table #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);
endmodule

[tb/sv/tb_first_fit_block_allocator.sv]
// Self-checking testbench for the first-fit block allocator: directed and random heap requests.
module tb_first_fit_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	localparam int MAXB = DEF_MAX_BLOCKS;
	localparam logic [31:0] HDR = 32'(DEF_HEADER_BYTES);
	localparam int PHASE_ITEMS = 132;
	localparam int SETTLE_CYCLES = 2 * MAXB + 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;

	ffba_stream_if #(.payload_t(req_t)) req_ch ();
	ffba_stream_if #(.payload_t(rsp_t)) rsp_ch ();
	ffba_stream_if #(.payload_t(logic [31:0])) cfg_ch ();

	first_fit_block_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	logic [31:0] blk_base [MAXB];
	logic [31:0] blk_size [MAXB];
	bit          blk_free [MAXB];
	int          blk_count;
	logic [31:0] brk_ptr;
	logic [31:0] heap_lim;

	req_t        req_backlog [$];
	rsp_t        answer_q [$];
	int          reqs_queued;
	int          reqs_sent;
	int unsigned mismatches;
	int unsigned send_gap;
	int unsigned rsp_stall;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned idle_cycles;
	bit          quiet;
	bit          offering;
	rsp_t        want;
	logic [31:0] phase_limit [6];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void take_block(input logic [31:0] size, output logic [31:0] addr,
			output logic [1:0] st);
		logic [33:0] end_ptr;
		addr = '0;
		st = ST_NOSPACE;
		if (size == 0)
			return;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_size[i] >= size) begin
				blk_free[i] = 1'b0;
				addr = blk_base[i] + HDR;
				st = ST_OK;
				return;
			end
		end
		end_ptr = {2'b00, brk_ptr} + {2'b00, HDR} + {2'b00, size};
		if (blk_count >= MAXB || end_ptr > {2'b00, heap_lim})
			return;
		blk_base[blk_count] = brk_ptr;
		blk_size[blk_count] = size;
		blk_free[blk_count] = 1'b0;
		blk_count++;
		brk_ptr = end_ptr[31:0];
		addr = blk_base[blk_count - 1] + HDR;
		st = ST_OK;
	endfunction

	function automatic int find_block(input logic [31:0] addr);
		for (int i = 0; i < blk_count; i++) begin
			if ({1'b0, blk_base[i]} + {1'b0, HDR} == {1'b0, addr})
				return i;
		end
		return -1;
	endfunction

	function automatic rsp_t serve_request(input req_t rq);
		rsp_t r;
		int idx;
		r = '0;
		case (rq.opcode)
			OP_ALLOC: begin
				take_block(rq.request_size, r.result_address, r.status);
			end
			OP_FREE: begin
				if (rq.address != 0) begin
					idx = find_block(rq.address);
					if (idx < 0 || blk_free[idx])
						r.status = ST_BADFREE;
					else
						blk_free[idx] = 1'b1;
				end
			end
			OP_REALLOC: begin
				if (rq.address == 0) begin
					take_block(rq.request_size, r.result_address, r.status);
				end else begin
					idx = find_block(rq.address);
					if (idx < 0 || blk_free[idx]) begin
						r.status = ST_BADFREE;
					end else if (blk_size[idx] >= rq.request_size) begin
						r.result_address = rq.address;
					end else begin
						take_block(rq.request_size, r.result_address, r.status);
						if (r.status == ST_OK) begin
							blk_free[idx] = 1'b1;
							r.moved = 1'b1;
							r.copy_length = blk_size[idx];
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_size();
		int unsigned p;
		logic [32:0] room;
		p = $urandom_range(0, 99);
		if (p < 60)
			return $urandom_range(1, 300);
		if (p < 70)
			return $urandom_range(300, 6000);
		if (p < 78)
			return '0;
		if (p < 86)
			return $urandom;
		room = {1'b0, heap_lim} - {1'b0, brk_ptr} - {1'b0, HDR};
		if (room[32] || room[31:0] == 0)
			return $urandom_range(1, 64);
		return (p < 93) ? room[31:0] : room[31:0] + 32'd1;
	endfunction

	function automatic logic [31:0] pick_addr();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 80 && blk_count > 0)
			return blk_base[$urandom_range(0, blk_count - 1)] + HDR;
		if (p < 88)
			return '0;
		if (p < 94 && blk_count > 0)
			return blk_base[$urandom_range(0, blk_count - 1)] + HDR + 32'd1;
		return $urandom;
	endfunction

	function automatic req_t random_req();
		req_t rq;
		int unsigned p;
		rq.opcode = OP_ALLOC;
		rq.request_size = pick_size();
		rq.address = pick_addr();
		p = $urandom_range(0, 99);
		if (p < 35) begin
			rq.opcode = OP_ALLOC;
		end else if (p < 60) begin
			rq.opcode = OP_FREE;
		end else if (p < 85) begin
			rq.opcode = OP_REALLOC;
		end else if (p < 90) begin
			rq.opcode = OP_NOP;
		end else begin
			rq.opcode = 2'($urandom_range(0, 3));
			rq.request_size = $urandom;
			rq.address = $urandom;
		end
		return rq;
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [31:0] size,
			input logic [31:0] addr);
		req_backlog.push_back('{opcode: op, request_size: size, address: addr});
		reqs_queued++;
	endtask

	task automatic wait_sent();
		do @(negedge clk); while (reqs_sent != reqs_queued);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (reqs_sent != reqs_queued || answer_q.size() != 0);
	endtask

	task automatic write_heap_limit(input logic [31:0] lim);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		cfg_ch.payload <= lim;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		heap_lim = lim;
		cfg_ch.valid <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				answer_q.push_back(serve_request(req_ch.payload));
				reqs_sent++;
				send_gap = quiet ? 0 : pick_gap();
				offering = 1'b0;
			end else begin
				offering = req_ch.valid;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_backlog.size() > 0) begin
					req_ch.payload <= req_backlog.pop_front();
					offering = 1'b1;
				end
			end
			req_ch.valid <= offering;
		end else begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answer_q.size() == 0) begin
					$error("result with no request outstanding: %p", rsp_ch.payload);
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (rsp_ch.payload.result_address !== want.result_address) begin
						$error("result_address: expected %0h, got %0h", want.result_address,
							rsp_ch.payload.result_address);
						mismatches++;
					end
					if (rsp_ch.payload.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							rsp_ch.payload.status);
						mismatches++;
					end
					if (rsp_ch.payload.moved !== want.moved) begin
						$error("moved: expected %0d, got %0d", want.moved, rsp_ch.payload.moved);
						mismatches++;
					end
					if (rsp_ch.payload.copy_length !== want.copy_length) begin
						$error("copy_length: expected %0d, got %0d", want.copy_length,
							rsp_ch.payload.copy_length);
						mismatches++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rsp_stall = LONG_HOLD;
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall = pick_gap();
				rsp_ch.ready <= (rsp_stall == 0);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int issued;
		int n;
		cfg_ch.valid <= 1'b0;
		cfg_ch.payload <= '0;
		arst_n = 1'b0;
		blk_count = 0;
		brk_ptr = '0;
		heap_lim = HEAP_LIMIT_RST;
		phase_limit = '{32'd4000, 32'd0, HEAP_LIMIT_RST, 32'd250000, 32'hFFFF_FFFF, 32'd1};
		phase_limit[3] = $urandom_range(100000, 2000000);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_req(OP_ALLOC, 32'd0, 32'd0);
		add_req(OP_ALLOC, 32'd100, 32'd0);
		add_req(OP_ALLOC, 32'd1, 32'd0);
		add_req(OP_FREE, 32'd0, 32'd0);
		add_req(OP_FREE, 32'd0, 32'd24);
		add_req(OP_FREE, 32'd0, 32'd24);
		add_req(OP_FREE, 32'd0, 32'd25);
		add_req(OP_ALLOC, 32'd50, 32'd0);
		add_req(OP_REALLOC, 32'd10, 32'd0);
		add_req(OP_REALLOC, 32'd100, 32'd24);
		add_req(OP_REALLOC, 32'd0, 32'd24);
		add_req(OP_REALLOC, 32'd200, 32'd148);
		add_req(OP_REALLOC, 32'd5, 32'd148);
		add_req(OP_REALLOC, 32'd5, 32'd999);
		add_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		add_req(OP_REALLOC, 32'hFFFF_FFFF, 32'd24);
		add_req(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(OP_REALLOC, 32'd0, 32'd0);
		add_req(OP_FREE, 32'd0, 32'hFFFF_FFFF);
		add_req(OP_ALLOC, 32'd1, 32'd0);
		add_req(OP_FREE, 32'd0, 32'd173);
		add_req(OP_REALLOC, 32'd101, 32'd24);
		add_req(OP_REALLOC, 32'd150, 32'd207);
		add_req(OP_ALLOC, 32'd65536, 32'd0);
		add_req(OP_FREE, 32'd0, 32'd207);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			write_heap_limit(phase_limit[ph]);
			if (ph == 1 || ph == 4) begin
				quiet = 1'b0;
				hold_req++;
			end
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				n = $urandom_range(4, 20);
				for (int k = 0; k < n; k++)
					req_backlog.push_back(random_req());
				reqs_queued += n;
				issued += n;
				wait_sent();
				quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 5) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[filelist.f]
rtl/ffba_pkg.sv
rtl/ffba_stream_if.sv
rtl/ffba_table.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
